// File: rtl/cldr_pkg.sv
// Shared types, constants and helpers of the circular log descriptor ring.
// Used by every module in rtl/; it depends on nothing else.
package cldr_pkg;

   localparam int SLOT_COUNT = 16;
   localparam int DATA_BYTES = 4096;
   localparam int WALK_LIMIT = 16;
   localparam int WALK_MAX   = (SLOT_COUNT < WALK_LIMIT) ? SLOT_COUNT : WALK_LIMIT;

   localparam int OP_W    = 2;
   localparam int KIND_W  = 2;
   localparam int SLOT_W  = 4;
   localparam int OFF_W   = 12;
   localparam int LEN_W   = 13;
   localparam int TIME_W  = 32;
   localparam int CNT_W   = 5;
   localparam int SUM_W   = LEN_W + 1;

   localparam int REQ_DATA_W = 72;
   localparam int RSP_DATA_W = 48;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [LEN_W-1:0] DB_LEN = LEN_W'(DATA_BYTES);
   localparam logic [SUM_W-1:0] DB_SUM = SUM_W'(DATA_BYTES);

   typedef enum logic [OP_W-1:0] {
      OP_RESTORE = 2'd0,
      OP_APPEND  = 2'd1,
      OP_READ    = 2'd2,
      OP_COUNT   = 2'd3
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACK   = 2'd0,
      KIND_SEG   = 2'd1,
      KIND_TOTAL = 2'd2,
      KIND_TRUNC = 2'd3
   } kind_type;

   // Classified command as it travels from the front end to the sequencer.
   typedef struct packed {
      op_type              op;
      logic [SLOT_W-1:0]   idx;
      logic [OFF_W-1:0]    off;
      logic [LEN_W-1:0]    len;
      logic [TIME_W-1:0]   tstamp;
      logic [CNT_W-1:0]    n;
   } cmd_type;

   // Queue head as seen by the sequencer.
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

   typedef struct packed {
      kind_type            kind;
      logic [SLOT_W-1:0]   slot;
      logic [OFF_W-1:0]    off;
      logic [LEN_W-1:0]    len;
      logic [LEN_W-1:0]    total;
      logic                last;
   } rsp_type;

   // One descriptor: offset, length and timestamp of a stored message.
   typedef struct packed {
      logic [OFF_W-1:0]  off;
      logic [LEN_W-1:0]  len;
      logic [TIME_W-1:0] tstamp;
   } entry_type;

   function automatic logic [SLOT_W-1:0] prev_slot(input logic [SLOT_W-1:0] s);
      return (s == '0) ? SLOT_W'(SLOT_COUNT - 1) : s - 1'b1;
   endfunction

   function automatic logic [SLOT_W-1:0] next_slot(input logic [SLOT_W-1:0] s);
      return (32'(s) + 1 >= SLOT_COUNT) ? '0 : s + 1'b1;
   endfunction

endpackage

// File: rtl/cldr_front.sv
// Front end of the descriptor ring: accepts request transactions and
// classifies them into commands (clamped length and walk count).
// Depends on cldr_pkg.
module cldr_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  cldr_pkg::cmd_type            in_raw,
   output logic                         cmd_valid,
   input  logic                         cmd_ready,
   output cldr_pkg::cmd_type            cmd
);

   logic              valid_ff, valid_in;
   cldr_pkg::cmd_type cmd_ff, cmd_in;
   logic              take;

   assign in_ready  = !valid_ff || cmd_ready;
   assign take      = in_valid && in_ready;
   assign cmd_valid = valid_ff;
   assign cmd       = cmd_ff;

   always_comb begin
      cmd_in = in_raw;
      // Offsets wrap into the data area, lengths saturate at its size.
      cmd_in.off = cldr_pkg::OFF_W'(32'(in_raw.off) % cldr_pkg::DATA_BYTES);
      if (in_raw.len > cldr_pkg::DB_LEN) begin
         cmd_in.len = cldr_pkg::DB_LEN;
      end
      if (32'(in_raw.n) > cldr_pkg::WALK_MAX) begin
         cmd_in.n = cldr_pkg::CNT_W'(cldr_pkg::WALK_MAX);
      end
      valid_in = take ? 1'b1 : (cmd_ready ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule

// File: rtl/cldr_queue.sv
// Short command queue between the front end and the sequencer of the
// descriptor ring. Depends on cldr_pkg.
module cldr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_valid,
   output logic                       push_ready,
   input  cldr_pkg::cmd_type          push_cmd,
   input  logic                       pop,
   output cldr_pkg::queue_out_type    head
);

   cldr_pkg::cmd_type              slots [cldr_pkg::QUEUE_DEPTH];
   logic [cldr_pkg::QPTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [cldr_pkg::QPTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [cldr_pkg::QCNT_W-1:0]    count_ff, count_in;
   logic                           do_push, do_pop;

   assign push_ready = (32'(count_ff) < cldr_pkg::QUEUE_DEPTH);
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && (count_ff != '0);
   assign head.valid = (count_ff != '0);
   assign head.cmd   = slots[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (32'(wr_ptr_ff) == cldr_pkg::QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == cldr_pkg::QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + cldr_pkg::QCNT_W'(do_push) - cldr_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// File: rtl/cldr_back.sv
// Sequencer of the descriptor ring: holds the descriptor memory, the write
// slot and the newest timestamp, and drives the result register. Depends on cldr_pkg.
module cldr_back (
   input  logic                      clock,
   input  logic                      reset,
   input  cldr_pkg::queue_out_type   head,
   output logic                      pop,
   output logic                      out_valid,
   input  logic                      out_ready,
   output cldr_pkg::rsp_type         out_data
);

   typedef enum logic [9:0] {
      ST_IDLE     = 10'b00_0000_0001,
      ST_RESTORE  = 10'b00_0000_0010,
      ST_APP_RD   = 10'b00_0000_0100,
      ST_APP_UPD  = 10'b00_0000_1000,
      ST_SEG      = 10'b00_0001_0000,
      ST_SEG2     = 10'b00_0010_0000,
      ST_WALK_RD  = 10'b00_0100_0000,
      ST_WALK_CHK = 10'b00_1000_0000,
      ST_WALK_END = 10'b01_0000_0000,
      ST_TRUNC    = 10'b10_0000_0000
   } state_type;

   state_type                          state_ff, state_in;
   cldr_pkg::cmd_type                  cmd_ff, cmd_in;
   logic [cldr_pkg::SLOT_W-1:0]        write_slot_ff, write_slot_in;
   logic [cldr_pkg::TIME_W-1:0]        newest_ff, newest_in;
   logic [cldr_pkg::SLOT_W-1:0]        slot_ff, slot_in;
   logic [cldr_pkg::CNT_W-1:0]         cnt_ff, cnt_in;
   logic [cldr_pkg::LEN_W-1:0]         sum_ff, sum_in;
   logic [cldr_pkg::OFF_W-1:0]         seg_off_ff, seg_off_in;
   logic [cldr_pkg::LEN_W-1:0]         seg_len_ff, seg_len_in;
   logic                               rsp_valid_ff, rsp_valid_in;
   cldr_pkg::rsp_type                  rsp_ff;

   cldr_pkg::entry_type                desc_mem [cldr_pkg::SLOT_COUNT];
   logic                               valid_ff [cldr_pkg::SLOT_COUNT];
   cldr_pkg::entry_type                rd_data_ff;
   logic                               rd_valid_ff;

   logic                               mem_we, mem_re;
   logic [cldr_pkg::SLOT_W-1:0]        mem_wa, mem_ra;
   cldr_pkg::entry_type                mem_wd;
   logic                               emit;
   cldr_pkg::rsp_type                  emit_data;
   logic                               out_free;

   cldr_pkg::entry_type                ent;
   logic [cldr_pkg::SUM_W-1:0]         link_sum, app_off, seg_end, walk_total;
   logic [cldr_pkg::TIME_W-1:0]        base_time;
   logic                               is_append, fin, seg_wrap;

   assign out_free  = !rsp_valid_ff || out_ready;
   assign out_valid = rsp_valid_ff;
   assign out_data  = rsp_ff;

   always_comb begin
      ent        = rd_valid_ff ? rd_data_ff : '0;
      link_sum   = cldr_pkg::SUM_W'(ent.off) + cldr_pkg::SUM_W'(ent.len);
      app_off    = (link_sum >= cldr_pkg::DB_SUM) ? link_sum - cldr_pkg::DB_SUM : link_sum;
      seg_end    = cldr_pkg::SUM_W'(seg_off_ff) + cldr_pkg::SUM_W'(seg_len_ff);
      seg_wrap   = seg_end > cldr_pkg::DB_SUM;
      walk_total = cldr_pkg::SUM_W'(sum_ff) + cldr_pkg::SUM_W'(ent.len);
      base_time  = (cmd_ff.idx == '0) ? '0 : newest_ff;
      is_append  = (cmd_ff.op == cldr_pkg::OP_APPEND);
      fin        = is_append || (cnt_ff == '0);
   end

   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      write_slot_in = write_slot_ff;
      newest_in     = newest_ff;
      slot_in       = slot_ff;
      cnt_in        = cnt_ff;
      sum_in        = sum_ff;
      seg_off_in    = seg_off_ff;
      seg_len_in    = seg_len_ff;
      pop           = 1'b0;
      mem_we        = 1'b0;
      mem_wa        = slot_ff;
      mem_wd        = '0;
      mem_re        = 1'b0;
      mem_ra        = slot_ff;
      emit          = 1'b0;
      emit_data     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop     = 1'b1;
               cmd_in  = head.cmd;
               slot_in = write_slot_ff;
               cnt_in  = head.cmd.n;
               sum_in  = '0;
               unique case (head.cmd.op)
                  cldr_pkg::OP_RESTORE: state_in = ST_RESTORE;
                  cldr_pkg::OP_APPEND:  state_in = ST_APP_RD;
                  cldr_pkg::OP_READ,
                  cldr_pkg::OP_COUNT:   state_in = ST_WALK_RD;
                  default:              state_in = ST_IDLE;
               endcase
            end
         end

         ST_RESTORE: begin
            if (out_free) begin
               if (32'(cmd_ff.idx) < cldr_pkg::SLOT_COUNT) begin
                  mem_we = 1'b1;
                  mem_wa = cmd_ff.idx;
                  mem_wd = '{off: cmd_ff.off, len: cmd_ff.len, tstamp: cmd_ff.tstamp};
                  if (cmd_ff.tstamp > base_time) begin
                     newest_in     = cmd_ff.tstamp;
                     write_slot_in = cldr_pkg::next_slot(cmd_ff.idx);
                  end else if (cmd_ff.idx == '0) begin
                     newest_in     = '0;
                     write_slot_in = '0;
                  end
               end
               emit           = 1'b1;
               emit_data.kind = cldr_pkg::KIND_ACK;
               emit_data.slot = cmd_ff.idx;
               emit_data.last = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         ST_APP_RD: begin
            mem_re   = 1'b1;
            mem_ra   = cldr_pkg::prev_slot(slot_ff);
            state_in = ST_APP_UPD;
         end

         ST_APP_UPD: begin
            // A previous slot that is all zero means the log starts over at 0.
            seg_off_in    = (ent == '0) ? '0 : cldr_pkg::OFF_W'(app_off);
            seg_len_in    = cmd_ff.len;
            mem_we        = 1'b1;
            mem_wa        = slot_ff;
            mem_wd        = '{off: seg_off_in, len: cmd_ff.len, tstamp: cmd_ff.tstamp};
            write_slot_in = cldr_pkg::next_slot(slot_ff);
            state_in      = ST_SEG;
         end

         ST_SEG: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.kind = cldr_pkg::KIND_SEG;
               emit_data.slot = slot_ff;
               emit_data.off  = seg_off_ff;
               if (seg_wrap) begin
                  emit_data.len = cldr_pkg::DB_LEN - cldr_pkg::LEN_W'(seg_off_ff);
                  state_in      = ST_SEG2;
               end else begin
                  emit_data.len  = seg_len_ff;
                  emit_data.last = fin;
                  state_in       = fin ? ST_IDLE : ST_WALK_RD;
               end
            end
         end

         ST_SEG2: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.kind = cldr_pkg::KIND_SEG;
               emit_data.slot = slot_ff;
               emit_data.len  = cldr_pkg::LEN_W'(seg_end - cldr_pkg::DB_SUM);
               emit_data.last = fin;
               state_in       = fin ? ST_IDLE : ST_WALK_RD;
            end
         end

         ST_WALK_RD: begin
            if (cnt_ff == '0) begin
               state_in = ST_WALK_END;
            end else begin
               slot_in  = cldr_pkg::prev_slot(slot_ff);
               mem_re   = 1'b1;
               mem_ra   = slot_in;
               cnt_in   = cnt_ff - 1'b1;
               state_in = ST_WALK_CHK;
            end
         end

         ST_WALK_CHK: begin
            if (walk_total > cldr_pkg::DB_SUM) begin
               if (cmd_ff.op == cldr_pkg::OP_READ) begin
                  state_in = ST_TRUNC;
               end else begin
                  sum_in   = cldr_pkg::DB_LEN;
                  state_in = ST_WALK_END;
               end
            end else begin
               sum_in = cldr_pkg::LEN_W'(walk_total);
               if (cmd_ff.op == cldr_pkg::OP_READ) begin
                  seg_off_in = ent.off;
                  seg_len_in = ent.len;
                  state_in   = ST_SEG;
               end else begin
                  state_in = ST_WALK_RD;
               end
            end
         end

         ST_TRUNC: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.kind = cldr_pkg::KIND_TRUNC;
               emit_data.slot = slot_ff;
               emit_data.len  = cldr_pkg::DB_LEN - sum_ff;
               emit_data.last = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         ST_WALK_END: begin
            if (out_free) begin
               emit           = 1'b1;
               emit_data.last = 1'b1;
               if (cmd_ff.op == cldr_pkg::OP_COUNT) begin
                  emit_data.kind  = cldr_pkg::KIND_TOTAL;
                  emit_data.total = sum_ff;
               end else begin
                  emit_data.kind = cldr_pkg::KIND_ACK;
               end
               state_in = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase

      rsp_valid_in = emit ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         write_slot_ff <= '0;
         newest_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < cldr_pkg::SLOT_COUNT; i++) begin
            valid_ff[i] <= 1'b0;
         end
      end else begin
         state_ff      <= state_in;
         write_slot_ff <= write_slot_in;
         newest_ff     <= newest_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (mem_we) begin
            valid_ff[mem_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff     <= cmd_in;
      slot_ff    <= slot_in;
      cnt_ff     <= cnt_in;
      sum_ff     <= sum_in;
      seg_off_ff <= seg_off_in;
      seg_len_ff <= seg_len_in;
      if (emit) begin
         rsp_ff <= emit_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         desc_mem[mem_wa] <= mem_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff  <= desc_mem[mem_ra];
         rd_valid_ff <= valid_ff[mem_ra];
      end
   end

endmodule

// File: rtl/circular_log_descriptor_ring.sv
// Top level of the circular log descriptor ring: stream ports, front end,
// command queue and sequencer. Depends on cldr_pkg, cldr_front, cldr_queue, cldr_back.
//
// Usage: each request transaction on the req_ channel carries one command in
// req_tuser (restore, append, read plan, count) and its operands in req_tdata.
// Every command returns one or more result transactions on the rsp_ channel;
// rsp_tlast marks the final one, rsp_tuser tells what it is.
// The front end classifies and registers a request and hands it to
// a two-entry queue, so new requests are taken while the sequencer works.
// The sequencer runs one command at a time against a 16-entry descriptor
// memory with one read port and registered read data. A read or a count
// walks back over up to 16 slots from the write slot; a read stops at a
// truncation mark and a count stops when its total saturates.
// Result transactions sit in an output register; when the receiver holds
// rsp_tready low the sequencer waits on it and the queue then fills, after
// which req_tready drops. Reset empties the queue, drops the result register,
// and marks every descriptor as all zero; write slot and newest timestamp clear.
module circular_log_descriptor_ring (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // entry_index[3:0], entry_offset[15:4], msg_length[28:16],
   // time_stamp[60:29], request_count[65:61], zero fill above
   input  logic [cldr_pkg::REQ_DATA_W-1:0]    req_tdata,
   // opcode[1:0]
   input  logic [cldr_pkg::OP_W-1:0]          req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // slot_index[3:0], seg_offset[15:4], seg_length[28:16],
   // byte_total[41:29], zero fill above
   output logic [cldr_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // kind[1:0]
   output logic [cldr_pkg::KIND_W-1:0]        rsp_tuser,
   output logic                               rsp_tlast
);

   cldr_pkg::cmd_type        raw_cmd;
   cldr_pkg::cmd_type        front_cmd;
   logic                     front_valid;
   logic                     queue_ready;
   logic                     queue_pop;
   cldr_pkg::queue_out_type  queue_head;
   cldr_pkg::rsp_type        rsp;

   // Unpack the request transaction into command fields.
   always_comb begin
      raw_cmd.op     = cldr_pkg::op_type'(req_tuser);
      raw_cmd.idx    = req_tdata[3:0];
      raw_cmd.off    = req_tdata[15:4];
      raw_cmd.len    = req_tdata[28:16];
      raw_cmd.tstamp = req_tdata[60:29];
      raw_cmd.n      = req_tdata[65:61];
   end

   cldr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_raw    (raw_cmd),
      .cmd_valid (front_valid),
      .cmd_ready (queue_ready),
      .cmd       (front_cmd)
   );

   cldr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (queue_ready),
      .push_cmd   (front_cmd),
      .pop        (queue_pop),
      .head       (queue_head)
   );

   cldr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (queue_head),
      .pop       (queue_pop),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp)
   );

   // Pack the result transaction.
   assign rsp_tdata = {6'b0, rsp.total, rsp.len, rsp.off, rsp.slot};
   assign rsp_tuser = rsp.kind;
   assign rsp_tlast = rsp.last;

endmodule

// File: verif/circular_log_descriptor_ring_test.sv
// Self-checking testbench for circular_log_descriptor_ring: drives commands on the
// req_ stream and checks every rsp_ transaction against a predictor of the ring.
// Depends on rtl/cldr_pkg.sv and rtl/circular_log_descriptor_ring.sv, and through it on the other rtl/ modules.
`timescale 1ns / 1ps

module circular_log_descriptor_ring_test;
   import cldr_pkg::*;

   // Traffic shaping: idle percentages change once this many commands went in.
   localparam int SWAP_IDLE_AT   = 60;
   localparam int NO_IDLE_AT     = 120;
   // The receiver stops for a long stretch once this many commands went in.
   localparam int HOLDOFF_AT     = 140;
   localparam int HOLDOFF_CYCLES = 400;
   localparam int TOTAL_CMDS     = 180;
   localparam int DRAIN_EVERY    = 50;
   // Long enough for a read walking every slot, with some margin.
   localparam int SETTLE_CYCLES  = 100;

   // One command as queued for the driver. The drain flag makes the driver wait
   // until every result of earlier commands has come back before offering it.
   typedef struct {
      op_type             op;
      logic [SLOT_W-1:0]  idx;
      logic [OFF_W-1:0]   off;
      logic [LEN_W-1:0]   len;
      logic [TIME_W-1:0]  tstamp;
      logic [CNT_W-1:0]   n;
      bit                 drain;
   } log_cmd_t;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata  = '0;
   logic [OP_W-1:0]         req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic [KIND_W-1:0]       rsp_tuser;
   logic                    rsp_tlast;

   circular_log_descriptor_ring dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Commands not yet accepted, and results predicted but not yet seen.
   log_cmd_t command_queue[$];
   rsp_type  awaited_results[$];

   // Predicted ring state: the descriptor table, the write slot, the newest time.
   logic [OFF_W-1:0]  desc_off  [SLOT_COUNT];
   logic [LEN_W-1:0]  desc_len  [SLOT_COUNT];
   logic [TIME_W-1:0] desc_time [SLOT_COUNT];
   int                ring_wr_slot = 0;
   logic [TIME_W-1:0] ring_newest  = '0;

   // Set by the monitor at each rising edge when a request transaction went through.
   bit       req_taken     = 1'b0;
   int       cmds_accepted = 0;
   int       mismatches    = 0;
   int       holdoff_left  = 0;
   bit       holdoff_done  = 1'b0;
   bit       drain_next    = 1'b0;
   log_cmd_t sent_cmd, next_cmd, seen_cmd;
   rsp_type  got_rsp, want_rsp;

   initial begin
      forever #2 clock = ~clock;
   end

   // Reset is asserted from the start and released on a falling edge.
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      foreach (desc_off[i]) begin
         desc_off[i]  = '0;
         desc_len[i]  = '0;
         desc_time[i] = '0;
      end
   end

   // ---------------------------------------------------------------------
   // Predictor of the descriptor ring.
   // ---------------------------------------------------------------------

   function automatic int slot_before(int s);
      return (s == 0) ? SLOT_COUNT - 1 : s - 1;
   endfunction

   function automatic int slot_after(int s);
      return (s + 1 >= SLOT_COUNT) ? 0 : s + 1;
   endfunction

   function automatic int saturate_length(int len);
      return (len > DATA_BYTES) ? DATA_BYTES : len;
   endfunction

   function automatic void push_result(kind_type kind, int slot, int off, int len,
                                       int total, bit last);
      rsp_type r;
      r.kind  = kind;
      r.slot  = SLOT_W'(slot);
      r.off   = OFF_W'(off);
      r.len   = LEN_W'(len);
      r.total = LEN_W'(total);
      r.last  = last;
      awaited_results.push_back(r);
   endfunction

   function automatic void mark_last();
      rsp_type r;
      r = awaited_results.pop_back();
      r.last = 1'b1;
      awaited_results.push_back(r);
   endfunction

   // A message that runs past the end of the data area shows up as two
   // segments: the tail of the area first, then the rest from offset zero.
   function automatic void emit_segments(int s);
      int o, l;
      o = desc_off[s];
      l = desc_len[s];
      if (o + l > DATA_BYTES) begin
         push_result(KIND_SEG, s, o, DATA_BYTES - o, 0, 1'b0);
         push_result(KIND_SEG, s, 0, o + l - DATA_BYTES, 0, 1'b0);
      end else begin
         push_result(KIND_SEG, s, o, l, 0, 1'b0);
      end
   endfunction

   // Updates the predicted ring for one accepted command and queues the
   // results that the block must return for it.
   function automatic void apply_log_command(log_cmd_t c);
      int cur, p, o, n, s, sum, i, first;
      bit cut;
      case (c.op)
         OP_RESTORE: begin
            // Restoring slot zero starts a new boot scan.
            if (c.idx == 0) begin
               ring_newest  = '0;
               ring_wr_slot = 0;
            end
            desc_off[c.idx]  = c.off;
            desc_len[c.idx]  = LEN_W'(saturate_length(c.len));
            desc_time[c.idx] = c.tstamp;
            if (c.tstamp > ring_newest) begin
               ring_newest  = c.tstamp;
               ring_wr_slot = slot_after(c.idx);
            end
            push_result(KIND_ACK, c.idx, 0, 0, 0, 1'b1);
         end
         OP_APPEND: begin
            cur = ring_wr_slot;
            p   = slot_before(cur);
            if (desc_off[p] == 0 && desc_len[p] == 0 && desc_time[p] == 0)
               o = 0;
            else
               o = (int'(desc_off[p]) + int'(desc_len[p])) % DATA_BYTES;
            desc_off[cur]  = OFF_W'(o);
            desc_len[cur]  = LEN_W'(saturate_length(c.len));
            desc_time[cur] = c.tstamp;
            emit_segments(cur);
            mark_last();
            ring_wr_slot = slot_after(cur);
         end
         default: begin
            // Read and count walk the newest slots backward from the write slot.
            n = c.n;
            if (n > WALK_MAX) n = WALK_MAX;
            s     = ring_wr_slot;
            sum   = 0;
            cut   = 1'b0;
            first = awaited_results.size();
            for (i = 0; i < n && !cut; i++) begin
               s = slot_before(s);
               if (sum + int'(desc_len[s]) > DATA_BYTES) begin
                  if (c.op == OP_READ)
                     push_result(KIND_TRUNC, s, 0, DATA_BYTES - sum, 0, 1'b1);
                  else
                     sum = DATA_BYTES;
                  cut = 1'b1;
               end else begin
                  sum += desc_len[s];
                  if (c.op == OP_READ) emit_segments(s);
               end
            end
            if (c.op == OP_COUNT)
               push_result(KIND_TOTAL, 0, 0, 0, sum, 1'b1);
            else if (awaited_results.size() == first)
               push_result(KIND_ACK, 0, 0, 0, 0, 1'b1);
            else if (!cut)
               mark_last();
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus construction.
   // ---------------------------------------------------------------------

   function automatic log_cmd_t random_cmd(op_type op);
      log_cmd_t c;
      c.op     = op;
      c.idx    = SLOT_W'($urandom);
      c.off    = OFF_W'($urandom);
      c.len    = LEN_W'($urandom);
      c.tstamp = $urandom;
      c.n      = CNT_W'($urandom);
      c.drain  = drain_next;
      drain_next = 1'b0;
      return c;
   endfunction

   function automatic void add_restore(int idx, int off, int len, logic [TIME_W-1:0] ts);
      log_cmd_t c;
      c        = random_cmd(OP_RESTORE);
      c.idx    = SLOT_W'(idx);
      c.off    = OFF_W'(off);
      c.len    = LEN_W'(len);
      c.tstamp = ts;
      command_queue.push_back(c);
   endfunction

   function automatic void add_append(int len, logic [TIME_W-1:0] ts);
      log_cmd_t c;
      c        = random_cmd(OP_APPEND);
      c.len    = LEN_W'(len);
      c.tstamp = ts;
      command_queue.push_back(c);
   endfunction

   function automatic void add_walk(op_type op, int n);
      log_cmd_t c;
      c   = random_cmd(op);
      c.n = CNT_W'(n);
      command_queue.push_back(c);
   endfunction

   // Mostly short messages so that a walk covers several slots, with some
   // long and oversized ones to reach wrapping, truncation and saturation.
   function automatic int pick_length();
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return $urandom_range(600);
      if (roll < 85) return $urandom_range(DATA_BYTES);
      if (roll < 93) return $urandom_range((1 << LEN_W) - 1);
      case ($urandom_range(3))
         0: return 0;
         1: return DATA_BYTES - 1;
         2: return DATA_BYTES;
         default: return DATA_BYTES + 1;
      endcase
   endfunction

   function automatic int pick_walk();
      return ($urandom_range(9) < 8) ? $urandom_range(SLOT_COUNT)
                                     : $urandom_range((1 << CNT_W) - 1);
   endfunction

   initial begin
      int roll, k, i, off, len, next_drain_at;
      logic [TIME_W-1:0] ts;

      // Directed part. The table is all zero after reset.
      add_walk(OP_READ, 0);                   // nothing to report: lone acknowledge
      add_walk(OP_COUNT, 31);                 // walk clamped, total of zero lengths
      add_walk(OP_READ, 2);                   // zero-length segments
      add_append(100, 32'hFFFF_FFFF);         // previous slot all zero: offset 0
      add_append(0, 32'h0);                   // zero length gives one empty segment
      add_restore(0, 4095, 8191, 32'hFFFF_FFFF);  // oversized length saturates
      add_restore(15, 0, 4097, 32'h0);        // older than newest: write slot stays
      add_append(4096, 32'd7);                // wraps: two segments
      add_append(8191, 32'd8);                // saturated and wrapping
      add_walk(OP_READ, 31);                  // truncation mark after first slot
      add_walk(OP_COUNT, 16);                 // saturated total
      add_walk(OP_COUNT, 1);
      add_restore(0, 0, 0, 32'h0);            // boot restart, slot 0 all zero
      add_append(300, 32'd9);
      add_restore(15, 0, 0, 32'h0);
      add_restore(0, 0, 0, 32'd1);
      add_restore(15, 2000, 50, 32'd1000);    // newest in last slot: write slot wraps
      add_append(200, 32'd1001);
      add_restore(5, 1234, 10, 32'h8000_0000);
      add_restore(9, 0, 0, 32'h7FFF_FFFF);    // smaller as unsigned: not newest
      add_append(4000, 32'd1002);
      add_walk(OP_READ, 16);
      add_walk(OP_READ, 17);
      add_walk(OP_COUNT, 0);
      add_walk(OP_COUNT, 5);

      // Random part: boot scans, appends, reads and counts,
      // with some stray restores in between.
      drain_next    = 1'b1;
      next_drain_at = command_queue.size() + DRAIN_EVERY;
      while (command_queue.size() < TOTAL_CMDS) begin
         if (command_queue.size() >= next_drain_at) begin
            drain_next     = 1'b1;
            next_drain_at += DRAIN_EVERY;
         end
         roll = $urandom_range(99);
         if (roll < 15) begin
            // Boot scan: slot 0 first, then consecutive slots whose messages
            // follow each other, with timestamps mostly rising.
            k   = $urandom_range(1, SLOT_COUNT);
            off = $urandom_range(DATA_BYTES - 1);
            ts  = $urandom;
            for (i = 0; i < k; i++) begin
               len = pick_length();
               add_restore(i, off, len, ts);
               off = (off + saturate_length(len)) % DATA_BYTES;
               ts  = ($urandom_range(9) == 0) ? $urandom : ts + $urandom_range(1, 1000);
            end
         end else if (roll < 55) begin
            add_append(pick_length(), $urandom);
         end else if (roll < 75) begin
            add_walk(OP_READ, pick_walk());
         end else if (roll < 92) begin
            add_walk(OP_COUNT, pick_walk());
         end else begin
            add_restore($urandom_range(SLOT_COUNT - 1), $urandom_range(DATA_BYTES - 1),
                        pick_length(), $urandom);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Driver: presents the head of the command queue at falling edges and
   // holds it until the transaction completes.
   // ---------------------------------------------------------------------
   always @(negedge clock) begin
      if (req_taken) sent_cmd = command_queue.pop_front();
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_taken) begin
         if (command_queue.size() != 0) next_cmd = command_queue[0];
         if (command_queue.size() != 0
             && $urandom_range(99) >= ((cmds_accepted < SWAP_IDLE_AT) ? 7 :
                                       (cmds_accepted < NO_IDLE_AT) ? 73 : 0)
             && !(next_cmd.drain && awaited_results.size() != 0)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {{(REQ_DATA_W - 66){1'b0}}, next_cmd.n, next_cmd.tstamp,
                           next_cmd.len, next_cmd.off, next_cmd.idx};
            req_tuser  <= next_cmd.op;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // Receiver: random back-pressure, plus one long hold-off during which the
   // sender keeps offering so that the block fills up and drops req_tready.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (holdoff_left > 0) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= holdoff_left - 1;
      end else if (!holdoff_done && cmds_accepted >= HOLDOFF_AT) begin
         rsp_tready   <= 1'b0;
         holdoff_left <= HOLDOFF_CYCLES;
         holdoff_done <= 1'b1;
      end else begin
         rsp_tready <= $urandom_range(99) >= ((cmds_accepted < SWAP_IDLE_AT) ? 73 :
                                              (cmds_accepted < NO_IDLE_AT) ? 7 : 0);
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: predicts on every accepted request transaction and checks every
   // accepted result transaction against the oldest prediction.
   // ---------------------------------------------------------------------
   function automatic void check_field(string name, logic [31:0] want, logic [31:0] seen);
      if (seen !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      req_taken = !reset && req_tvalid && req_tready;
      if (req_taken) begin
         seen_cmd.op     = op_type'(req_tuser);
         seen_cmd.idx    = req_tdata[3:0];
         seen_cmd.off    = req_tdata[15:4];
         seen_cmd.len    = req_tdata[28:16];
         seen_cmd.tstamp = req_tdata[60:29];
         seen_cmd.n      = req_tdata[65:61];
         apply_log_command(seen_cmd);
         cmds_accepted++;
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_rsp.kind  = kind_type'(rsp_tuser);
         got_rsp.slot  = rsp_tdata[3:0];
         got_rsp.off   = rsp_tdata[15:4];
         got_rsp.len   = rsp_tdata[28:16];
         got_rsp.total = rsp_tdata[41:29];
         got_rsp.last  = rsp_tlast;
         if (awaited_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual kind %0d slot %0d",
                     $time, got_rsp.kind, got_rsp.slot);
            mismatches++;
         end else begin
            want_rsp = awaited_results.pop_front();
            check_field("kind", want_rsp.kind, got_rsp.kind);
            check_field("slot_index", want_rsp.slot, got_rsp.slot);
            check_field("seg_offset", want_rsp.off, got_rsp.off);
            check_field("seg_length", want_rsp.len, got_rsp.len);
            check_field("byte_total", want_rsp.total, got_rsp.total);
            check_field("last", want_rsp.last, got_rsp.last);
         end
      end
   end

   // End of test: all commands in, all results back, then a quiet spell in
   // which any stray result transaction would still be caught.
   initial begin
      @(negedge reset);
      while (command_queue.size() != 0 || req_tvalid || awaited_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
